>>> hdl/lev_pkg.sv
// Shared types and constants for the Levenshtein distance block.
`default_nettype none

package lev_pkg;

    localparam int MAX_LEN_DEF     = 64;
    // Count field in the command is sized for the largest supported MAX_LEN (2047)
    localparam int CNT_W           = 11;
    localparam int DIST_W          = 7;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

    typedef struct packed {
        logic       which_string;
        logic [7:0] char_byte;
        logic       is_last;
        logic       is_empty;
    } in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } out_t;

    typedef enum logic {
        OP_FIRST,
        OP_SECOND
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             has_byte;
        logic             ends;
        logic             overflow;
        logic [7:0]       char_byte;
        logic [CNT_W-1:0] count;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_RESULT
    } back_state_t;

endpackage

`default_nettype wire

>>> hdl/lev_front.sv
// Front end: takes input transfers, tracks string phase and lengths, issues commands.
`default_nettype none

module lev_front #(
    parameter int MAX_LEN = lev_pkg::MAX_LEN_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lev_pkg::in_t  s_data,
    input  wire logic          q_full,
    output logic               push,
    output lev_pkg::cmd_t      cmd
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic             phase_reg, phase_next;
    logic [LEN_W-1:0] first_len_reg, first_len_next;
    logic [LEN_W-1:0] second_len_reg, second_len_next;
    logic             ovf_reg, ovf_next;

    logic             accept;
    logic             match;
    logic             ends;
    logic             room;
    logic             take;
    logic             drop;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] new_len;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign match   = (s_data.which_string == phase_reg);
    assign ends    = s_data.is_last || s_data.is_empty;
    assign cur_len = phase_reg ? second_len_reg : first_len_reg;
    assign room    = (cur_len < LEN_W'(MAX_LEN));
    assign take    = !s_data.is_empty && room;
    assign drop    = !s_data.is_empty && !room;
    assign new_len = take ? cur_len + LEN_W'(1) : cur_len;

    // items for the other string are swallowed without a command
    assign push = accept && match && (take || ends);

    always_comb begin
        cmd.op        = phase_reg ? lev_pkg::OP_SECOND : lev_pkg::OP_FIRST;
        cmd.has_byte  = take;
        cmd.ends      = ends;
        cmd.overflow  = ovf_reg || drop;
        cmd.char_byte = s_data.char_byte;
        cmd.count     = lev_pkg::CNT_W'(new_len);
    end

    always_comb begin
        phase_next      = phase_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        if (accept && match) begin
            ovf_next = ovf_reg || drop;
            if (!phase_reg) begin
                first_len_next = new_len;
                if (ends) begin
                    phase_next      = 1'b1;
                    second_len_next = '0;
                end
            end else begin
                second_len_next = new_len;
                if (ends) begin
                    phase_next      = 1'b0;
                    first_len_next  = '0;
                    second_len_next = '0;
                    ovf_next        = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= 1'b0;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lev_queue.sv
// Small command FIFO between front end and back end.
`default_nettype none

module lev_queue #(
    parameter int DEPTH = lev_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire lev_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output lev_pkg::cmd_t      pop_data,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lev_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lev_back.sv
// Back end: first-string store, cost row sweep and result register.
`default_nettype none

module lev_back #(
    parameter int MAX_LEN = lev_pkg::MAX_LEN_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire lev_pkg::cmd_t cmd,
    input  wire logic          q_empty,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lev_pkg::out_t      m_data
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int COST_W = LEN_W + 1;
    localparam int SAT_W  = (LEN_W > lev_pkg::DIST_W) ? LEN_W : lev_pkg::DIST_W;

    lev_pkg::back_state_t state_reg, state_next;

    logic [7:0]       first_mem_reg [MAX_LEN];
    logic [LEN_W-1:0] row_mem_reg   [MAX_LEN];
    logic [7:0]       first_q_reg;
    logic [LEN_W-1:0] row_q_reg;

    logic [LEN_W-1:0] first_len_reg;
    logic [LEN_W-1:0] cell_reg;
    logic [LEN_W-1:0] left_reg;
    logic [LEN_W-1:0] diag_reg;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] last_cost_reg;
    logic [7:0]       byte_reg;
    logic             fresh_reg;
    logic             ends_reg;
    logic             ovf_reg;
    logic             m_valid_reg;
    lev_pkg::out_t    m_data_reg;

    logic [LEN_W-1:0]          cmd_len;
    logic                      is_second;
    logic                      start_sweep;
    logic                      last_cell;
    logic                      out_free;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      row_wr_en;
    logic                      first_wr_en;
    logic                      load_out;
    logic [LEN_W-1:0]          up;
    logic [COST_W-1:0]         cost_up;
    logic [COST_W-1:0]         cost_left;
    logic [COST_W-1:0]         cost_sub;
    logic [COST_W-1:0]         cost_min;
    logic [LEN_W-1:0]          new_cost;
    logic [LEN_W-1:0]          res_len;
    logic [SAT_W-1:0]          res_wide;
    logic [lev_pkg::DIST_W-1:0] res_dist;

    assign cmd_len     = cmd.count[LEN_W-1:0];
    assign is_second   = (cmd.op == lev_pkg::OP_SECOND);
    assign start_sweep = (state_reg == lev_pkg::BK_IDLE) && !q_empty && is_second
                         && cmd.has_byte && (first_len_reg != '0);
    assign last_cell   = (cell_reg == first_len_reg);
    assign out_free    = !m_valid_reg || m_ready;

    // one cell of the cost row per cycle
    always_comb begin
        up        = fresh_reg ? cell_reg : row_q_reg;
        cost_up   = COST_W'(up) + COST_W'(1);
        cost_left = COST_W'(left_reg) + COST_W'(1);
        cost_sub  = COST_W'(diag_reg) + COST_W'(first_q_reg != byte_reg);
        cost_min  = (cost_up < cost_left) ? cost_up : cost_left;
        cost_min  = (cost_sub < cost_min) ? cost_sub : cost_min;
        new_cost  = cost_min[LEN_W-1:0];
    end

    // empty second string: distance is the first string's length
    always_comb begin
        res_len  = (count_reg == '0) ? first_len_reg : last_cost_reg;
        res_wide = SAT_W'(res_len);
        res_dist = (res_wide > SAT_W'(lev_pkg::DIST_MAX)) ? lev_pkg::DIST_MAX
                                                        : res_wide[lev_pkg::DIST_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lev_pkg::BK_IDLE: begin
                if (!q_empty && is_second) begin
                    if (start_sweep) begin
                        state_next = lev_pkg::BK_SWEEP;
                    end else if (cmd.ends) begin
                        state_next = lev_pkg::BK_RESULT;
                    end
                end
            end
            lev_pkg::BK_SWEEP: begin
                if (last_cell) begin
                    state_next = ends_reg ? lev_pkg::BK_RESULT : lev_pkg::BK_IDLE;
                end
            end
            lev_pkg::BK_RESULT: begin
                if (out_free) begin
                    state_next = lev_pkg::BK_IDLE;
                end
            end
            default: state_next = lev_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        row_wr_en   = 1'b0;
        first_wr_en = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            lev_pkg::BK_IDLE: begin
                pop         = !q_empty;
                rd_en       = start_sweep;
                first_wr_en = !q_empty && !is_second && cmd.has_byte;
            end
            lev_pkg::BK_SWEEP: begin
                row_wr_en = 1'b1;
                rd_en     = !last_cell;
                rd_addr   = cell_reg[ADDR_W-1:0];
            end
            lev_pkg::BK_RESULT: begin
                load_out = out_free;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lev_pkg::BK_IDLE;
            m_valid_reg   <= 1'b0;
            first_len_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop && !is_second && cmd.ends) begin
                first_len_reg <= cmd_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            byte_reg <= cmd.char_byte;
            ends_reg <= cmd.ends;
            ovf_reg  <= cmd.overflow;
            if (is_second) begin
                count_reg <= cmd_len;
                fresh_reg <= (cmd_len == LEN_W'(1));
                left_reg  <= cmd_len;
                diag_reg  <= cmd_len - LEN_W'(1);
                cell_reg  <= LEN_W'(1);
                if (cmd.has_byte && (first_len_reg == '0)) begin
                    last_cost_reg <= cmd_len;
                end
            end
        end else if (state_reg == lev_pkg::BK_SWEEP) begin
            left_reg <= new_cost;
            diag_reg <= up;
            cell_reg <= cell_reg + LEN_W'(1);
            if (last_cell) begin
                last_cost_reg <= new_cost;
            end
        end
        if (load_out) begin
            m_data_reg.distance <= res_dist;
            m_data_reg.overflow <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (first_wr_en) begin
            first_mem_reg[cmd_len[ADDR_W-1:0] - ADDR_W'(1)] <= cmd.char_byte;
        end
        if (rd_en) begin
            first_q_reg <= first_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (row_wr_en) begin
            row_mem_reg[cell_reg[ADDR_W-1:0] - ADDR_W'(1)] <= new_cost;
        end
        if (rd_en) begin
            row_q_reg <= row_mem_reg[rd_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> hdl/levenshtein_distance.sv
// Top level of the Levenshtein edit distance block.
//
// Input channel (s_valid/s_ready/s_data): one transfer per byte. Bytes of the
// first string (which_string = 0) come first, up to the one marked is_last, or
// an is_empty transfer that ends it without a byte; then the second string
// (which_string = 1) the same way. Transfers for the other string are dropped.
// Bytes past MAX_LEN in either string are dropped and raise the overflow flag.
// Result channel (m_valid/m_ready/m_data): one transfer per string pair,
// distance saturated at 127, overflow set if a string was cut.
// Throughput: first-string bytes go at one per cycle while the queue has room.
// Each second-string byte is swept in the back end one cell of the cost row per
// cycle, since the row lives in a one-write one-read memory.
// With the queue empty and the back end idle, the ending command passes the queue,
// a sweep if it and string one hold bytes, then the result state that sets m_valid.
// A 4-entry command queue sits between front and back, so input keeps flowing
// while a sweep runs or the result register waits on m_ready.
// Reset (aresetn low, synchronous) empties the queue, drops any half-loaded
// pair and clears m_valid; no clearing pass is needed afterwards.
// A stalled receiver holds the result; the back end stops once it has the
// next result ready, and s_ready falls when the queue fills.
`default_nettype none

module levenshtein_distance #(
    parameter int MAX_LEN     = lev_pkg::MAX_LEN_DEF,
    parameter int QUEUE_DEPTH = lev_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire lev_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output lev_pkg::out_t      m_data
);

    lev_pkg::cmd_t push_cmd;
    lev_pkg::cmd_t pop_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    // phase and length tracking, one command per useful transfer
    lev_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .push    (push),
        .cmd     (push_cmd)
    );

    lev_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .empty     (q_empty)
    );

    // string store, cost row sweep and output register
    lev_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (pop_cmd),
        .q_empty (q_empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> hdl/lev_check.sv
// Port-level checks for the Levenshtein distance block, bound to the top level.
`default_nettype none

module lev_check #(
    parameter int MAX_LEN = lev_pkg::MAX_LEN_DEF
) (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire lev_pkg::out_t m_data
);

    localparam int LIMIT = (MAX_LEN < 127) ? MAX_LEN : 127;

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // distance can never exceed MAX_LEN or the saturation value 127
    a_distance_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.distance <= 7'(LIMIT)))
        else $error("distance out of range");

    // input ready stays known after a transfer
    a_ready_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$isunknown(s_ready))
        else $error("input ready unknown");

endmodule

bind levenshtein_distance lev_check #(
    .MAX_LEN (MAX_LEN)
) u_lev_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

>>> test/tb.sv
// Testbench for levenshtein_distance: directed and random string pairs against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_LEN   = lev_pkg::MAX_LEN_DEF;
    // Longest quiet spell is a full queue of second-string bytes, each swept
    // over up to MAX_LEN cells, plus receiver stalls; this is several times that.
    localparam int STALL_MAX = 3000;
    // Pause at the end: one sweep of the longest row plus the output pipeline.
    localparam int SETTLE    = 200;

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    lev_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    lev_pkg::out_t m_data;

    levenshtein_distance i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predictor state: first string as kept, the running cost row and the phase.
    logic [7:0]    first_chars [MAX_LEN];
    int            cost_row [MAX_LEN + 1];
    int            first_len    = 0;
    int            second_len   = 0;
    lev_pkg::op_t  cur_string   = lev_pkg::OP_FIRST;
    bit            cut_seen     = 1'b0;

    lev_pkg::out_t pending_distances [$];
    int            transfers_in = 0;  // every input transfer
    int            taken_items  = 0;  // transfers for the string being loaded
    int            errors       = 0;
    int            quiet_cycles = 0;
    bit            calm         = 1'b0;  // no idling on either side while set

    // Advance the predictor by one accepted input transfer. Returns 1 with the
    // expected result when the transfer ends the second string.
    function automatic bit track_edit_distance(input lev_pkg::in_t item,
                                               output lev_pkg::out_t res);
        int  i;
        int  diag;
        int  up;
        int  best;
        bit  ends;
        res  = '0;
        ends = item.is_last || item.is_empty;
        // transfers for the other string are dropped whole
        if (item.which_string != cur_string) return 1'b0;
        if (cur_string == lev_pkg::OP_FIRST) begin
            if (!item.is_empty) begin
                if (first_len < MAX_LEN) begin
                    first_chars[first_len] = item.char_byte;
                    first_len++;
                end else begin
                    cut_seen = 1'b1;
                end
            end
            if (ends) begin
                for (i = 0; i <= first_len; i++) cost_row[i] = i;
                second_len = 0;
                cur_string = lev_pkg::OP_SECOND;
            end
            return 1'b0;
        end
        if (!item.is_empty) begin
            if (second_len < MAX_LEN) begin
                diag = cost_row[0];
                second_len++;
                cost_row[0] = second_len;
                for (i = 1; i <= first_len; i++) begin
                    up   = cost_row[i];
                    best = diag + ((first_chars[i - 1] != item.char_byte) ? 1 : 0);
                    if (up + 1 < best) best = up + 1;
                    if (cost_row[i - 1] + 1 < best) best = cost_row[i - 1] + 1;
                    cost_row[i] = best;
                    diag = up;
                end
            end else begin
                cut_seen = 1'b1;
            end
        end
        if (!ends) return 1'b0;
        best = cost_row[first_len];
        if (best > int'(lev_pkg::DIST_MAX)) best = int'(lev_pkg::DIST_MAX);
        res.distance = best[lev_pkg::DIST_W-1:0];
        res.overflow = cut_seen;
        first_len  = 0;
        second_len = 0;
        cur_string = lev_pkg::OP_FIRST;
        cut_seen   = 1'b0;
        return 1'b1;
    endfunction

    // All sampling at the rising edge: input transfers feed the predictor,
    // result transfers are checked in order, and the watchdog counts edges
    // with no transfer on either channel.
    always @(posedge aclk) begin
        lev_pkg::out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                transfers_in++;
                if (s_data.which_string == cur_string) taken_items++;
                if (track_edit_distance(s_data, want))
                    pending_distances.insert(pending_distances.size(), want);
            end
            if (m_valid && m_ready) begin
                if (pending_distances.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, got distance %0d overflow %0b",
                             $time, m_data.distance, m_data.overflow);
                end else begin
                    want = pending_distances.pop_front();
                    if (m_data.distance !== want.distance) begin
                        errors++;
                        $display("%0t: distance expected %0d, got %0d",
                                 $time, want.distance, m_data.distance);
                    end
                    if (m_data.overflow !== want.overflow) begin
                        errors++;
                        $display("%0t: overflow expected %0b, got %0b",
                                 $time, want.overflow, m_data.overflow);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver back-pressure: m_ready drops with a 15 percent chance unless calm.
    always @(negedge aclk) m_ready <= calm || ($urandom_range(0, 99) >= 15);

    // One input transfer. Entered at a falling edge; returns at the falling
    // edge after acceptance with valid still high, so a following item can go
    // out back to back unless a random pause comes first.
    task automatic send_item(input lev_pkg::op_t which, input logic [7:0] ch,
                             input bit last, input bit empty);
        int seen;
        while (!calm && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        seen = transfers_in;
        s_valid <= 1'b1;
        s_data  <= '{which_string: which, char_byte: ch, is_last: last, is_empty: empty};
        @(negedge aclk);
        while (transfers_in == seen) @(negedge aclk);
    endtask

    // Hold the sender off until every expected result has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_distances.size() != 0) @(negedge aclk);
    endtask

    // Mostly short strings; now and then empty, or near or past the length limit.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
        if (r < 12) return 0;
        return $urandom_range(1, 10);
    endfunction

    // Small alphabet most of the time so that bytes often match.
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 99) < 60) return 8'($urandom_range(8'h61, 8'h64));
        return 8'($urandom_range(0, 255));
    endfunction

    // One string. Ends on is_last with its final byte, or with a separate
    // empty mark (always so for an empty string). Noise transfers for the
    // other string are slipped in now and then and must be dropped.
    task automatic send_string(input lev_pkg::op_t which, input logic [7:0] chars[$],
                               input bit mark_alone, input int noise_pct);
        lev_pkg::op_t other;
        other = (which == lev_pkg::OP_FIRST) ? lev_pkg::OP_SECOND : lev_pkg::OP_FIRST;
        foreach (chars[i]) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(other, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            send_item(which, chars[i], !mark_alone && (i == chars.size() - 1), 1'b0);
        end
        if (mark_alone || chars.size() == 0)
            send_item(which, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // A random pair; half the time the second string is a lightly edited
    // copy of the first so that small distances turn up.
    task automatic random_pair(input int noise_pct);
        logic [7:0] a[$];
        logic [7:0] b[$];
        int         n;
        int         pos;
        int         r;
        n = pick_len();
        repeat (n) a.insert(a.size(), pick_char());
        if ($urandom_range(0, 1)) begin
            b = a;
            repeat ($urandom_range(0, 3)) begin
                pos = $urandom_range(0, b.size());
                r   = $urandom_range(0, 2);
                if (r == 0) b.insert(pos, pick_char());
                else if (pos < b.size() && r == 1) b.delete(pos);
                else if (pos < b.size()) b[pos] = pick_char();
            end
        end else begin
            n = pick_len();
            repeat (n) b.insert(b.size(), pick_char());
        end
        send_string(lev_pkg::OP_FIRST, a, $urandom_range(0, 3) == 0, noise_pct);
        send_string(lev_pkg::OP_SECOND, b, $urandom_range(0, 3) == 0, noise_pct);
    endtask

    // Empty strings on either side, ended with and without is_last.
    task automatic test_empty_strings();
        send_item(lev_pkg::OP_FIRST, 8'hFF, 1'b0, 1'b1);
        send_item(lev_pkg::OP_SECOND, 8'h00, 1'b1, 1'b1);   // both empty: distance 0
        send_item(lev_pkg::OP_FIRST, 8'h61, 1'b0, 1'b0);
        send_item(lev_pkg::OP_FIRST, 8'h62, 1'b1, 1'b0);
        send_item(lev_pkg::OP_SECOND, 8'h7F, 1'b0, 1'b1);   // empty second: first length
        drain();
    endtask

    // Byte values at both ends of the range.
    task automatic test_byte_extremes();
        send_item(lev_pkg::OP_FIRST, 8'h00, 1'b0, 1'b0);
        send_item(lev_pkg::OP_FIRST, 8'hFF, 1'b1, 1'b0);
        send_item(lev_pkg::OP_SECOND, 8'hFF, 1'b0, 1'b0);
        send_item(lev_pkg::OP_SECOND, 8'h00, 1'b1, 1'b0);
        send_item(lev_pkg::OP_FIRST, 8'h80, 1'b1, 1'b0);
        send_item(lev_pkg::OP_SECOND, 8'h80, 1'b1, 1'b0);
        drain();
    endtask

    // Transfers naming the wrong string change nothing, end marks included.
    task automatic test_wrong_selector();
        send_item(lev_pkg::OP_SECOND, 8'h7A, 1'b1, 1'b0);
        send_item(lev_pkg::OP_FIRST, 8'h78, 1'b1, 1'b0);
        send_item(lev_pkg::OP_FIRST, 8'h77, 1'b1, 1'b1);
        send_item(lev_pkg::OP_SECOND, 8'h79, 1'b1, 1'b0);
        drain();
    endtask

    // An empty mark after bytes keeps them and ends the string.
    task automatic test_empty_mark_after_bytes();
        send_item(lev_pkg::OP_FIRST, 8'h61, 1'b0, 1'b0);
        send_item(lev_pkg::OP_FIRST, 8'h62, 1'b0, 1'b0);
        send_item(lev_pkg::OP_FIRST, 8'h00, 1'b1, 1'b1);
        send_item(lev_pkg::OP_SECOND, 8'h62, 1'b0, 1'b0);
        send_item(lev_pkg::OP_SECOND, 8'hFF, 1'b0, 1'b1);
        drain();
    endtask

    // Strings at and past MAX_LEN: cut bytes set overflow, a cut byte marked
    // last still ends its string, and exactly MAX_LEN bytes is no overflow.
    task automatic test_length_limit();
        logic [7:0] a[$];
        logic [7:0] b[$];
        repeat (MAX_LEN + 1) a.insert(a.size(), pick_char());
        repeat (2) b.insert(b.size(), pick_char());
        send_string(lev_pkg::OP_FIRST, a, 1'b0, 0);
        send_string(lev_pkg::OP_SECOND, b, 1'b0, 0);
        a.delete();
        b.delete();
        repeat (3) a.insert(a.size(), pick_char());
        repeat (MAX_LEN + 2) b.insert(b.size(), pick_char());
        send_string(lev_pkg::OP_FIRST, a, 1'b0, 0);
        send_string(lev_pkg::OP_SECOND, b, 1'b1, 0);
        a.delete();
        b.delete();
        repeat (MAX_LEN) a.insert(a.size(), pick_char());
        repeat (MAX_LEN) b.insert(b.size(), pick_char());
        send_string(lev_pkg::OP_FIRST, a, 1'b0, 0);
        send_string(lev_pkg::OP_SECOND, b, 1'b0, 0);
        drain();
    endtask

    // Random pairs until count transfers for the loading string have gone
    // in; the sender waits for all results now and then.
    task automatic test_random_pairs(input int count, input bit quiet);
        int goal;
        calm = quiet;
        goal = taken_items + count;
        while (taken_items < goal) begin
            random_pair(quiet ? 3 : 8);
            if ($urandom_range(0, 24) == 0) drain();
        end
        drain();
        calm = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_strings();
        test_byte_extremes();
        test_wrong_selector();
        test_empty_mark_after_bytes();
        test_length_limit();
        test_random_pairs(580, 1'b0);
        test_random_pairs(270, 1'b1);

        drain();
        repeat (SETTLE) @(negedge aclk);
        if (errors == 0 && pending_distances.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
